// ===== hw/rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W = 32;   // result numerator width
    localparam int DEN_W = 31;   // result denominator width

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2,
        ACT_DIV = 3'd3, ACT_INC = 3'd4, ACT_DEC = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PROD, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic prod;      // form cross products
        logic sum;       // form num/den, magnitudes, gcd seed
        logic gcd_step;  // one binary gcd step
        logic div_start; // seed divider
        logic div_step;  // one restoring division bit
        logic div_sel_d; // 0: dividing numerator, 1: denominator
        logic div_save;  // store quotient
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;       // immediate error
        logic zero;      // numerator magnitude zero
        logic gcd_done;
        logic div_done;
    } t_status;
endpackage

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: fraction add/sub/mul/div/inc/dec with gcd reduction.
// Sequence: cross products, sum and sign, binary gcd, then restoring division of the
// numerator and then the denominator magnitude by the gcd, 2W quotient bits each.
// Errors and zero results skip gcd and division.
// One request in flight; the next is accepted in the cycle after the result is taken.
// Synchronous active-low reset idles the sequencer; datapath registers are not reset.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] action, then a_numerator, a_denominator, b_numerator, b_denominator
    input  logic [((3 + 4*OPERAND_WIDTH - 2 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_numerator, [62:32] result_denominator, [63] status
    output logic [63:0] m_axis_tdata
);
    localparam int W = OPERAND_WIDTH;
    localparam int AN_LO = 3;
    localparam int AD_LO = AN_LO + W;
    localparam int BN_LO = AD_LO + W - 1;
    localparam int BD_LO = BN_LO + W;

    t_cmd    s_cmd;
    t_status s_sts;
    logic    s_busy, s_valid, s_status;
    logic signed [RES_W-1:0] s_num;
    logic [DEN_W-1:0]        s_den;

    // Ready whenever idle; result held in datapath registers while waiting.
    assign s_axis_tready = !s_busy;
    assign m_axis_tvalid = s_valid;
    assign m_axis_tdata  = {s_status, s_den, s_num};

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_fire (m_axis_tvalid && m_axis_tready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd),
        .o_busy     (s_busy),
        .o_valid    (s_valid)
    );

    rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (s_cmd),
        .i_action  (s_axis_tdata[2:0]),
        .i_a_num   (s_axis_tdata[AN_LO +: W]),
        .i_a_den   (s_axis_tdata[AD_LO +: W-1]),
        .i_b_num   (s_axis_tdata[BN_LO +: W]),
        .i_b_den   (s_axis_tdata[BD_LO +: W-1]),
        .o_sts     (s_sts),
        .o_res_num (s_num),
        .o_res_den (s_den),
        .o_status  (s_status)
    );
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// Sequencer for the rational arithmetic unit.
module rau_ctrl import rau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_out_fire,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_in_fire;
                if (i_in_fire) n_state = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_GCD;
            end
            ST_GCD: begin
                if (i_sts.err || i_sts.zero) begin
                    n_state = ST_OUT;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIVN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_save = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_d = 1'b1;
                    n_state = ST_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_DIVD: begin
                o_cmd.div_sel_d = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.div_save = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_out_fire) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/rau_dp.sv =====
// Datapath: cross products, sign, binary gcd, restoring divider.
module rau_dp import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  t_cmd                            i_cmd,
    input  logic [2:0]                      i_action,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic [OPERAND_WIDTH-2:0]        i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic [OPERAND_WIDTH-2:0]        i_b_den,
    output t_status                         o_sts,
    output logic signed [RES_W-1:0]         o_res_num,
    output logic [DEN_W-1:0]                o_res_den,
    output logic                            o_status
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;    // signed product/sum width
    localparam int MW = 2 * W;        // magnitude width
    localparam int CW = $clog2(MW + 1);

    logic [2:0]          r_act;
    logic signed [W-1:0] r_an, r_bn;
    logic [W-2:0]        r_ad, r_bd;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic                r_err, r_zero, r_neg;
    logic [MW-1:0]       r_nm, r_dm, r_gx, r_gy, r_g;
    logic [CW-1:0]       r_gk;
    logic [MW-1:0]       r_q, r_rem, r_dvd;
    logic [CW-1:0]       r_cnt;
    logic [MW-1:0]       r_qn, r_qd;

    logic signed [W:0]    s_an, s_bn, s_ad, s_bd;
    logic signed [PW-1:0] s_num, s_den;
    logic                 s_err;
    logic [MW:0]          s_trial;
    logic [MW-1:0]        s_nrem;

    assign s_an = {r_an[W-1], r_an};
    assign s_bn = {r_bn[W-1], r_bn};
    assign s_ad = {2'b00, r_ad};
    assign s_bd = {2'b00, r_bd};

    always_comb begin
        case (r_act)
            ACT_ADD: begin s_num = r_p0 + r_p1; s_den = r_p2; end
            ACT_SUB: begin s_num = r_p0 - r_p1; s_den = r_p2; end
            default: begin s_num = r_p0;        s_den = r_p1; end
        endcase
        s_err = (r_act > ACT_DEC) || (r_ad == '0) ||
                (r_act <= ACT_DIV && r_bd == '0) || (s_den == '0);
    end

    assign s_nrem  = {r_rem[MW-2:0], r_dvd[MW-1]};
    assign s_trial = {1'b0, s_nrem} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an <= i_a_num; r_bn <= i_b_num;
            r_ad <= i_a_den; r_bd <= i_b_den;
        end
        if (i_cmd.prod) begin
            case (r_act)
                ACT_ADD, ACT_SUB: begin
                    r_p0 <= PW'(s_an) * PW'(s_bd);
                    r_p1 <= PW'(s_bn) * PW'(s_ad);
                    r_p2 <= PW'(s_ad) * PW'(s_bd);
                end
                ACT_MUL: begin
                    r_p0 <= PW'(s_an) * PW'(s_bn);
                    r_p1 <= PW'(s_ad) * PW'(s_bd);
                    r_p2 <= '0;
                end
                ACT_DIV: begin
                    r_p0 <= PW'(s_an) * PW'(s_bd);
                    r_p1 <= PW'(s_ad) * PW'(s_bn);
                    r_p2 <= '0;
                end
                ACT_INC: begin
                    r_p0 <= PW'(s_an) + PW'(s_ad);
                    r_p1 <= PW'(s_ad);
                    r_p2 <= '0;
                end
                default: begin
                    r_p0 <= PW'(s_an) - PW'(s_ad);
                    r_p1 <= PW'(s_ad);
                    r_p2 <= '0;
                end
            endcase
        end
        if (i_cmd.sum) begin
            r_err  <= s_err;
            r_zero <= !s_err && (s_num == '0);
            r_neg  <= s_num[PW-1] ^ s_den[PW-1];
            r_nm   <= MW'(s_num[PW-1] ? -s_num : s_num);
            r_dm   <= MW'(s_den[PW-1] ? -s_den : s_den);
            r_gx   <= MW'(s_num[PW-1] ? -s_num : s_num);
            r_gy   <= MW'(s_den[PW-1] ? -s_den : s_den);
            r_gk   <= '0;
        end
        // binary gcd: strip common twos, strip lone twos, subtract odd from odd
        if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx > r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
        if (i_cmd.div_start) begin
            r_g   <= r_gx << r_gk;
            r_dvd <= i_cmd.div_sel_d ? r_dm : r_nm;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[MW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (!s_trial[MW]) begin
                r_rem <= s_trial[MW-1:0];
                r_q   <= {r_q[MW-2:0], 1'b1};
            end else begin
                r_rem <= s_nrem;
                r_q   <= {r_q[MW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_save) begin
            if (i_cmd.div_sel_d && !i_cmd.div_start) r_qd <= r_q;
            else                                     r_qn <= r_q;
        end
    end

    assign o_sts.err      = r_err;
    assign o_sts.zero     = r_zero;
    assign o_sts.gcd_done = (r_gx == r_gy);
    assign o_sts.div_done = (r_cnt == CW'(MW));

    logic [RES_W-1:0] s_mag;
    assign s_mag = RES_W'(r_qn);
    always_comb begin
        if (r_err) begin
            o_res_num = '0; o_res_den = '0; o_status = 1'b1;
        end else if (r_zero) begin
            o_res_num = '0; o_res_den = DEN_W'(1); o_status = 1'b0;
        end else begin
            o_res_num = r_neg ? -s_mag : s_mag;
            o_res_den = DEN_W'(r_qd);
            o_status  = 1'b0;
        end
    end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rational arithmetic unit.
module tb import rau_pkg::*; ;

    localparam int W      = OPERAND_WIDTH_DEF;
    localparam int IN_W   = ((3 + 4*W - 2 + 7) / 8) * 8;
    localparam int N_RAND = 1700;
    localparam longint LIMIT = 8_000_000;
    // action codes beyond the enum; the unit flags them as errors
    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;

    typedef struct packed {
        logic        status;
        logic [30:0] den;
        logic [31:0] num;
    } t_frac_res;

    typedef struct {
        logic [IN_W-1:0] data;
        logic            drain;   // hold until every result is back
    } t_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;

    t_req      req_q[$];
    t_frac_res frac_q[$];
    int        n_err = 0;
    int        n_sent = 0;
    int        n_got = 0;
    int        n_fault = 0;
    longint    cyc = 0;

    always #5 i_clk = ~i_clk;

    rational_arithmetic_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [IN_W-1:0] pack_req(logic [2:0] act, longint an, longint ad,
                                                 longint bn, longint bd);
        logic [IN_W-1:0] d;
        d = '0;
        d[2:0]           = act;
        d[3 +: W]        = an[W-1:0];
        d[3+W +: W-1]    = ad[W-2:0];
        d[2+2*W +: W]    = bn[W-1:0];
        d[2+3*W +: W-1]  = bd[W-2:0];
        return d;
    endfunction

    // Unreduced num/den and an error flag for one request.
    function automatic void cross_terms(logic [IN_W-1:0] d, output bit bad,
                                        output longint num, output longint den);
        logic [2:0] act;
        longint an, ad, bn, bd;
        act = d[2:0];
        an  = longint'($signed(d[3 +: W]));
        ad  = longint'(d[3+W +: W-1]);
        bn  = longint'($signed(d[2+2*W +: W]));
        bd  = longint'(d[2+3*W +: W-1]);
        bad = 1'b0;
        num = 0;
        den = 0;
        if (act > ACT_DEC || ad == 0 || (act <= ACT_DIV && bd == 0)) begin
            bad = 1'b1;
            return;
        end
        case (act)
            ACT_ADD: begin num = an*bd + bn*ad; den = ad*bd; end
            ACT_SUB: begin num = an*bd - bn*ad; den = ad*bd; end
            ACT_MUL: begin num = an*bn; den = ad*bd; end
            ACT_DIV: begin num = an*bd; den = ad*bn; end
            ACT_INC: begin num = an + ad; den = ad; end
            default: begin num = an - ad; den = ad; end
        endcase
        if (den == 0) bad = 1'b1;
    endfunction

    function automatic t_frac_res reduce_frac(logic [IN_W-1:0] d);
        t_frac_res r;
        bit bad, neg;
        longint num, den, x, y, t;
        cross_terms(d, bad, num, den);
        r = '0;
        if (bad) begin
            r.status = 1'b1;
            return r;
        end
        if (num == 0) begin
            r.den = 31'd1;
            return r;
        end
        neg = (num < 0) != (den < 0);
        x = (num < 0) ? -num : num;
        y = (den < 0) ? -den : den;
        num = x;
        den = y;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        num = num / x;
        den = den / x;
        r.num = 32'(neg ? -num : num);
        r.den = den[30:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        n_err++;
        $display("[%0d] result %0d %s: got %0d, want %0d", cyc, n_got, what, got, want);
    endtask

    function automatic longint rnd_num(bit wide);
        if (wide) return longint'($signed(16'($urandom)));
        return longint'($urandom_range(510)) - 255;
    endfunction

    function automatic longint rnd_den(bit wide);
        if ($urandom_range(99) < 3) return 0;
        if (wide) return longint'($urandom_range(32767, 1));
        return longint'($urandom_range(255, 1));
    endfunction

    // Stimulus: directed corner cases, then random requests.
    initial begin
        logic [IN_W-1:0] d;
        logic [2:0] act;
        bit wide;
        t_req r;
        r.drain = 1'b0;
        r.data = pack_req(ACT_ADD, 1, 2, 1, 3);        req_q.push_back(r);
        r.data = pack_req(ACT_SUB, 3, 4, 5, 6);        req_q.push_back(r);
        r.data = pack_req(ACT_MUL, -7, 9, 3, 14);      req_q.push_back(r);
        r.data = pack_req(ACT_DIV, 5, 8, -15, 4);      req_q.push_back(r);
        r.data = pack_req(ACT_INC, -9, 4, 77, 0);      req_q.push_back(r);
        r.data = pack_req(ACT_DEC, 3, 7, -1, 5);       req_q.push_back(r);
        // zero result comes out as 0/1
        r.data = pack_req(ACT_ADD, 1, 2, -1, 2);       req_q.push_back(r);
        r.data = pack_req(ACT_DEC, 6, 6, 0, 0);        req_q.push_back(r);
        r.data = pack_req(ACT_MUL, 0, 5, 1234, 7);     req_q.push_back(r);
        // zero denominators and division by zero
        r.data = pack_req(ACT_ADD, 5, 0, 1, 3);        req_q.push_back(r);
        r.data = pack_req(ACT_SUB, 5, 3, 1, 0);        req_q.push_back(r);
        r.data = pack_req(ACT_INC, 5, 0, 1, 1);        req_q.push_back(r);
        r.data = pack_req(ACT_DIV, 5, 3, 0, 9);        req_q.push_back(r);
        // unused action codes
        r.data = pack_req(ACT_BAD6, 1, 1, 1, 1);       req_q.push_back(r);
        r.data = pack_req(ACT_BAD7, -1, 32767, -1, 32767); req_q.push_back(r);
        // field extremes
        r.data = pack_req(ACT_ADD, -32768, 32767, 32767, 32767);  req_q.push_back(r);
        r.data = pack_req(ACT_MUL, -32768, 32767, 32767, 32767);  req_q.push_back(r);
        r.data = pack_req(ACT_SUB, -32768, 1, 32767, 1);          req_q.push_back(r);
        r.data = pack_req(ACT_DIV, -32768, 32767, -32768, 32767); req_q.push_back(r);
        r.data = pack_req(ACT_INC, 32767, 32767, -32768, 32767);  req_q.push_back(r);
        r.data = pack_req(ACT_DEC, -32768, 32767, 0, 0);          req_q.push_back(r);

        for (int i = 0; i < N_RAND; i++) begin
            act  = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
            wide = ($urandom_range(4) == 0);
            d = pack_req(act, rnd_num(wide), rnd_den(wide), rnd_num(wide), rnd_den(wide));
            r.data  = d;
            r.drain = (i % 400 == 200);
            req_q.push_back(r);
        end
    end

    // Driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        bit   took;
        logic nxt_valid;
        t_req r;
        took = s_axis_tvalid && s_axis_tready;
        nxt_valid = s_axis_tvalid;
        if (i_rst_n) begin
            if (took) begin
                frac_q.push_back(reduce_frac(s_axis_tdata));
                n_sent++;
            end
            if (!s_axis_tvalid || took) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() > 0 &&
                             !(req_q[0].drain && frac_q.size() > 0)) begin
                    r = req_q.pop_front();
                    s_axis_tdata <= r.data;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(12);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // Receiver stall pattern: the mode is chosen by cycle counter bits [9:8].
    always @(posedge i_clk) begin
        case (cyc[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= 1'($urandom_range(1));
            2'd2:    m_axis_tready <= (cyc[5:3] != 3'd0);
            default: m_axis_tready <= ($urandom_range(7) == 0);
        endcase
    end

    // Monitor: compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_frac_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_frac_res'(m_axis_tdata);
            n_got++;
            if (frac_q.size() == 0) begin
                report("unexpected", 0, 0);
            end else begin
                want = frac_q.pop_front();
                if (want.status) n_fault++;
                if (got.num != want.num)
                    report("numerator", longint'($signed(got.num)),
                           longint'($signed(want.num)));
                if (got.den != want.den)
                    report("denominator", longint'(got.den), longint'(want.den));
                if (got.status != want.status)
                    report("status", longint'(got.status), longint'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles, %0d requests pending", cyc, frac_q.size());
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (req_q.size() > 0 || s_axis_tvalid || frac_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (frac_q.size() > 0) report("left over", frac_q.size(), 0);
        $display("sent %0d requests of all six operations plus unused codes; %0d results",
                 n_sent, n_got);
        $display("checked, %0d of them error status; %0d mismatches", n_fault, n_err);
        if (n_err == 0) begin
            $display("rational_arithmetic_unit: match");
        end else begin
            $display("rational_arithmetic_unit: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_arithmetic_unit.sv
tb/tb.sv
